// ----- src/onewire_rom_search_engine_macros.svh -----
// Assertion macros shared by the search engine modules
`ifndef ONEWIRE_ROM_SEARCH_ENGINE_MACROS_SVH
`define ONEWIRE_ROM_SEARCH_ENGINE_MACROS_SVH

// Check a condition at every clock edge outside reset
`define OWRSE_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle
`define OWRSE_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- src/owrse_pkg.sv -----
// Shared types and constants of the 1-Wire ROM search engine
package owrse_pkg;

   localparam int RomBits     = 64;
   localparam int PosBits     = 7;
   localparam int FamBits     = 4;
   localparam int CrcBits     = 8;
   localparam int FifoDepth   = 4;
   localparam int FifoPtrBits = 2;
   localparam int FifoCntBits = 3;

   localparam logic [CrcBits-1:0] CrcPoly     = 8'h8C;
   localparam logic [PosBits-1:0] LastPos     = 7'd64;
   localparam logic [PosBits-1:0] VerifyDisc  = 7'd64;
   localparam logic [PosBits-1:0] FamilyLimit = 7'd9;

   // Input item kinds
   typedef enum logic [2:0] {
      KIND_FIRST    = 3'd0,
      KIND_NEXT     = 3'd1,
      KIND_VERIFY   = 3'd2,
      KIND_TARGET   = 3'd3,
      KIND_SKIP     = 3'd4,
      KIND_PRESENCE = 3'd5,
      KIND_BIT_PAIR = 3'd6
   } kind_type;

   // Result item actions
   typedef enum logic [2:0] {
      ACT_SETUP   = 3'd0,
      ACT_RESET   = 3'd1,
      ACT_COMMAND = 3'd2,
      ACT_WRITE   = 3'd3,
      ACT_DONE    = 3'd4,
      ACT_IGNORED = 3'd5
   } action_type;

   // Broadcast command from the controller to every bit cell
   typedef struct packed {
      logic start;
      logic advance;
      logic write_en;
      logic dir;
      logic load_family;
      logic save;
      logic restore;
   } cell_cmd_type;

   typedef struct packed {
      logic [2:0]         action;
      logic               direction;
      logic               found;
      logic [RomBits-1:0] rom_code;
      logic               last;
   } rsp_item_type;

   // Up to two result items pushed in one cycle
   typedef struct packed {
      logic         first;
      logic         second;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

endpackage

// ----- src/owrse_req_if.sv -----
// Input channel of the search engine
interface owrse_req_if import owrse_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic       presence;
   logic       id_bit;
   logic       compl_bit;
   logic [7:0] fam_byte;

   modport source (output valid, kind, presence, id_bit, compl_bit, fam_byte,
                   input ready);
   modport sink   (input valid, kind, presence, id_bit, compl_bit, fam_byte,
                   output ready);
endinterface

// ----- src/owrse_rsp_if.sv -----
// Result channel of the search engine
interface owrse_rsp_if import owrse_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [2:0]         action;
   logic               direction;
   logic               found;
   logic [RomBits-1:0] rom_code;
   logic               last;

   modport source (output valid, action, direction, found, rom_code, last, input ready);
   modport sink   (input valid, action, direction, found, rom_code, last, output ready);
endinterface

// ----- src/onewire_rom_search_engine.sv -----
// Top level of the 1-Wire ROM search engine
//
// req_ch carries one item per handshake: a search command (first, next, verify),
// a family setup (target, skip), the presence result of a bus reset, or one
// id/complement bit pair read from the bus. rsp_ch returns the action for the
// bus master: setup done, do a bus reset, send the search command, write a bit
// (with its direction), search done (with found) or ignored, plus the current ROM code.
// Most items give one result; the bit pair of the last code bit gives two, a
// write bit followed by search done, and the last flag marks the final one.
// The ROM code lives in a row of 64 bit cells that pass a one-hot position
// token from cell to cell, one step per bit pair; CRC-8 is updated serially.
// Results are registered in the result queue before they appear on rsp_ch.
// Throughput: one item per cycle while req_ch.ready is high; a four-entry
// result queue takes new items while results wait to be read.
// If rsp_ch stalls, the queue fills and req_ch.ready drops once fewer than
// two free entries remain. Reset clears all search state, the queue and the
// saved copy; the position token returns to the first cell.
`include "onewire_rom_search_engine_macros.svh"
module onewire_rom_search_engine import owrse_pkg::*; (
   input logic         clock,
   input logic         reset,
   owrse_req_if.sink   req_ch,
   owrse_rsp_if.source rsp_ch
);

   cell_cmd_type        cmd;
   push_type            push;
   logic                can_accept;
   logic                fire;
   logic [RomBits:0]    tok_chain;
   logic [RomBits-1:0]  token_vec;
   logic [RomBits-1:0]  rom_vec;
   logic [RomBits-1:0]  pick_vec;
   logic [RomBits-1:0]  match_vec;
   logic [RomBits-1:0]  rom_next_vec;
   logic [RomBits-1:0]  load_vec;

   assign req_ch.ready = can_accept;
   assign fire         = req_ch.valid && can_accept;
   assign load_vec     = {{(RomBits-8){1'b0}}, req_ch.fam_byte};
   assign tok_chain[0] = 1'b0;
   assign token_vec    = tok_chain[RomBits:1];

   owrse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .kind       (req_ch.kind),
      .presence   (req_ch.presence),
      .id_bit     (req_ch.id_bit),
      .compl_bit  (req_ch.compl_bit),
      .rom_sel    (|pick_vec),
      .match_all  (&match_vec),
      .rom_low    (rom_vec[7:0]),
      .rom_next   (rom_next_vec),
      .cmd        (cmd),
      .push       (push)
   );

   // Row of bit cells, token travelling from bit zero upward
   for (genvar i = 0; i < RomBits; i++) begin : g_cell
      owrse_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .first_in     ((i == 0) ? 1'b1 : 1'b0),
         .token_in     (tok_chain[i]),
         .load_in      (load_vec[i]),
         .token_out    (tok_chain[i+1]),
         .rom_out      (rom_vec[i]),
         .pick_out     (pick_vec[i]),
         .match_out    (match_vec[i]),
         .rom_next_out (rom_next_vec[i])
      );
   end

   owrse_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .can_accept (can_accept),
      .rsp_ch     (rsp_ch)
   );

   `OWRSE_ASSERT_ALWAYS(a_token_onehot, $onehot0(token_vec), "position token not one-hot")

endmodule

// ----- src/owrse_cell.sv -----
// One ROM code bit cell: current bit, saved bit and search position token
module owrse_cell import owrse_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  logic         first_in,
   input  logic         token_in,
   input  logic         load_in,
   output logic         token_out,
   output logic         rom_out,
   output logic         pick_out,
   output logic         match_out,
   output logic         rom_next_out
);

   logic rom_ff, rom_in;
   logic saved_ff, saved_in;
   logic token_ff, token_in_nxt;
   logic rom_wr;

   // Take the direction bit when the token sits here
   assign rom_wr = (cmd.write_en && token_ff) ? cmd.dir : rom_ff;

   always_comb begin
      rom_in = rom_wr;
      if (cmd.restore) begin
         rom_in = saved_ff;
      end else if (cmd.load_family) begin
         rom_in = load_in;
      end
      saved_in = cmd.save ? rom_ff : saved_ff;
      token_in_nxt = token_ff;
      if (cmd.start) begin
         token_in_nxt = first_in;
      end else if (cmd.advance) begin
         token_in_nxt = token_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_ff   <= 1'b0;
         saved_ff <= 1'b0;
         token_ff <= first_in;
      end else begin
         rom_ff   <= rom_in;
         saved_ff <= saved_in;
         token_ff <= token_in_nxt;
      end
   end

   assign token_out    = token_ff;
   assign rom_out      = rom_ff;
   assign pick_out     = rom_ff & token_ff;
   assign match_out    = (rom_wr == saved_ff);
   assign rom_next_out = rom_in;

endmodule

// ----- src/owrse_ctrl.sv -----
// Search controller: phase, discrepancy counters, CRC and result generation
`include "onewire_rom_search_engine_macros.svh"
module owrse_ctrl import owrse_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic [2:0]         kind,
   input  logic               presence,
   input  logic               id_bit,
   input  logic               compl_bit,
   input  logic               rom_sel,
   input  logic               match_all,
   input  logic [7:0]         rom_low,
   input  logic [RomBits-1:0] rom_next,
   output cell_cmd_type       cmd,
   output push_type           push
);

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_PRESENCE = 2'd1,
      PH_BITS     = 2'd2
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [PosBits-1:0]   ld_ff, ld_in;
   logic [FamBits-1:0]   fd_ff, fd_in;
   logic                 ldev_ff, ldev_in;
   logic [PosBits-1:0]   bp_ff, bp_in;
   logic [PosBits-1:0]   lzp_ff, lzp_in;
   logic [CrcBits-1:0]   crc_ff, crc_in;
   logic                 verify_ff, verify_in;
   logic [PosBits-1:0]   sld_ff, sld_in;
   logic                 sdev_ff, sdev_in;
   logic [FamBits-1:0]   sfd_ff, sfd_in;

   logic               do_finish, finish_ok, ok, two;
   logic               dir, fnd, fb;
   action_type         act;
   logic [CrcBits-1:0] crc_nxt;

   always_comb begin
      phase_in  = phase_ff;
      ld_in     = ld_ff;
      fd_in     = fd_ff;
      ldev_in   = ldev_ff;
      bp_in     = bp_ff;
      lzp_in    = lzp_ff;
      crc_in    = crc_ff;
      verify_in = verify_ff;
      sld_in    = sld_ff;
      sdev_in   = sdev_ff;
      sfd_in    = sfd_ff;
      cmd       = '0;
      act       = ACT_IGNORED;
      dir       = 1'b0;
      fnd       = 1'b0;
      two       = 1'b0;
      do_finish = 1'b0;
      finish_ok = 1'b0;
      ok        = 1'b0;
      fb        = 1'b0;
      crc_nxt   = crc_ff;

      if (fire) begin
         if (phase_ff != PH_IDLE && kind <= KIND_SKIP) begin
            // Ignore search commands and family setups while a search runs
            act = ACT_IGNORED;
         end else begin
            unique case (kind) inside
               KIND_FIRST, KIND_NEXT, KIND_VERIFY: begin
                  if (kind == KIND_FIRST) begin
                     ld_in   = '0;
                     ldev_in = 1'b0;
                     fd_in   = '0;
                  end
                  if (kind == KIND_VERIFY) begin
                     cmd.save  = 1'b1;
                     sld_in    = ld_ff;
                     sdev_in   = ldev_ff;
                     sfd_in    = fd_ff;
                     ld_in     = VerifyDisc;
                     ldev_in   = 1'b0;
                     verify_in = 1'b1;
                  end
                  bp_in     = PosBits'(1);
                  lzp_in    = '0;
                  crc_in    = '0;
                  cmd.start = 1'b1;
                  // After the last device the bus is left alone
                  if (kind == KIND_NEXT && ldev_ff) begin
                     do_finish = 1'b1;
                     act       = ACT_DONE;
                  end else begin
                     phase_in = PH_PRESENCE;
                     act      = ACT_RESET;
                  end
               end
               KIND_TARGET: begin
                  cmd.load_family = 1'b1;
                  ld_in   = VerifyDisc;
                  fd_in   = '0;
                  ldev_in = 1'b0;
                  act     = ACT_SETUP;
               end
               KIND_SKIP: begin
                  ld_in = PosBits'(fd_ff);
                  fd_in = '0;
                  if (fd_ff == '0) begin
                     ldev_in = 1'b1;
                  end
                  act = ACT_SETUP;
               end
               KIND_PRESENCE: begin
                  if (phase_ff == PH_PRESENCE) begin
                     if (!presence) begin
                        do_finish = 1'b1;
                        act       = ACT_DONE;
                     end else begin
                        phase_in = PH_BITS;
                        act      = ACT_COMMAND;
                     end
                  end
               end
               KIND_BIT_PAIR: begin
                  if (phase_ff == PH_BITS) begin
                     if (id_bit && compl_bit) begin
                        // No device answered: abort
                        do_finish = 1'b1;
                        act       = ACT_DONE;
                     end else begin
                        if (id_bit != compl_bit) begin
                           dir = id_bit;
                        end else begin
                           if (bp_ff < ld_ff) begin
                              dir = rom_sel;
                           end else begin
                              dir = (bp_ff == ld_ff);
                           end
                           if (!dir) begin
                              lzp_in = bp_ff;
                              if (bp_ff < FamilyLimit) begin
                                 fd_in = bp_ff[FamBits-1:0];
                              end
                           end
                        end
                        cmd.write_en = 1'b1;
                        cmd.dir      = dir;
                        cmd.advance  = 1'b1;
                        // Serial CRC-8 step
                        fb      = crc_ff[0] ^ dir;
                        crc_nxt = (crc_ff >> 1) ^ (fb ? CrcPoly : '0);
                        crc_in  = crc_nxt;
                        bp_in   = bp_ff + PosBits'(1);
                        act     = ACT_WRITE;
                        if (bp_ff == LastPos) begin
                           two       = 1'b1;
                           do_finish = 1'b1;
                           finish_ok = (crc_nxt == '0);
                           if (finish_ok) begin
                              ld_in = lzp_in;
                              if (lzp_in == '0) begin
                                 ldev_in = 1'b1;
                              end
                           end
                        end
                     end
                  end
               end
               default: begin
                  act = ACT_IGNORED;
               end
            endcase
         end

         // End the search, restoring the saved state after a verify
         if (do_finish) begin
            ok = finish_ok && (rom_low != '0);
            if (!ok) begin
               ld_in   = '0;
               ldev_in = 1'b0;
               fd_in   = '0;
            end
            fnd = ok;
            if (verify_ff) begin
               fnd         = ok && match_all;
               cmd.restore = 1'b1;
               ld_in       = sld_ff;
               ldev_in     = sdev_ff;
               fd_in       = sfd_ff;
               verify_in   = 1'b0;
            end
            phase_in = PH_IDLE;
         end
      end

      // Build the result items
      push.first            = fire;
      push.second           = fire && two;
      push.item0.action     = two ? ACT_WRITE : act;
      push.item0.direction  = dir;
      push.item0.found      = two ? 1'b0 : fnd;
      push.item0.rom_code   = rom_next;
      push.item0.last       = !two;
      push.item1.action     = ACT_DONE;
      push.item1.direction  = 1'b0;
      push.item1.found      = fnd;
      push.item1.rom_code   = rom_next;
      push.item1.last       = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         ld_ff     <= '0;
         fd_ff     <= '0;
         ldev_ff   <= 1'b0;
         bp_ff     <= PosBits'(1);
         lzp_ff    <= '0;
         crc_ff    <= '0;
         verify_ff <= 1'b0;
         sld_ff    <= '0;
         sdev_ff   <= 1'b0;
         sfd_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         ld_ff     <= ld_in;
         fd_ff     <= fd_in;
         ldev_ff   <= ldev_in;
         bp_ff     <= bp_in;
         lzp_ff    <= lzp_in;
         crc_ff    <= crc_in;
         verify_ff <= verify_in;
         sld_ff    <= sld_in;
         sdev_ff   <= sdev_in;
         sfd_ff    <= sfd_in;
      end
   end

   `OWRSE_ASSERT_IMPLY(a_verify_busy, verify_ff, phase_ff != PH_IDLE, "verify outside a search")
   `OWRSE_ASSERT_IMPLY(a_bits_pos, phase_ff == PH_BITS, bp_ff >= PosBits'(1) && bp_ff <= LastPos, "bit position out of range")
   `OWRSE_ASSERT_IMPLY(a_start_pos, phase_ff == PH_PRESENCE, bp_ff == PosBits'(1) && crc_ff == '0, "search not restarted")

endmodule

// ----- src/owrse_out_fifo.sv -----
// Result queue: takes up to two items a cycle, hands out one
`include "onewire_rom_search_engine_macros.svh"
module owrse_out_fifo import owrse_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       can_accept,
   owrse_rsp_if.source rsp_ch
);

   rsp_item_type             entry_ff [FifoDepth];
   logic [FifoPtrBits-1:0]   wr_ff, wr_in;
   logic [FifoPtrBits-1:0]   rd_ff, rd_in;
   logic [FifoCntBits-1:0]   count_ff, count_in;
   logic                     pop;

   assign pop = rsp_ch.valid && rsp_ch.ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_in    = wr_ff + FifoPtrBits'(push.first) + FifoPtrBits'(push.second);
      rd_in    = rd_ff + FifoPtrBits'(pop);
      count_in = count_ff + FifoCntBits'(push.first) + FifoCntBits'(push.second)
                 - FifoCntBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Store the items
   always_ff @(posedge clock) begin
      if (push.first) begin
         entry_ff[wr_ff] <= push.item0;
      end
      if (push.second) begin
         entry_ff[wr_ff + FifoPtrBits'(1)] <= push.item1;
      end
   end

   assign can_accept       = (count_ff <= FifoCntBits'(FifoDepth - 2));
   assign rsp_ch.valid     = (count_ff != '0);
   assign rsp_ch.action    = entry_ff[rd_ff].action;
   assign rsp_ch.direction = entry_ff[rd_ff].direction;
   assign rsp_ch.found     = entry_ff[rd_ff].found;
   assign rsp_ch.rom_code  = entry_ff[rd_ff].rom_code;
   assign rsp_ch.last      = entry_ff[rd_ff].last;

   `OWRSE_ASSERT_ALWAYS(a_fifo_count, count_ff <= FifoCntBits'(FifoDepth), "result queue overflow")

endmodule
